@@ sv/pfe_pkg.sv @@
// Shared types and constants for the Playfair digraph encrypt unit.
// Used by pfe_ctrl, pfe_datapath and playfair_digraph_encrypt_unit.
package pfe_pkg;

  // Letter indexes and square geometry
  localparam int LetterW  = 5;
  localparam int SqDim    = 5;
  localparam int SqCells  = SqDim * SqDim;
  localparam int LetCount = 26;
  localparam int PosW     = $clog2(SqCells + 1);
  localparam logic [LetterW-1:0] LetI    = LetterW'(8);
  localparam logic [LetterW-1:0] LetJ    = LetterW'(9);
  localparam logic [LetterW-1:0] LetX    = LetterW'(23);
  localparam logic [LetterW-1:0] LetLast = LetterW'(LetCount - 1);

  // Operation codes
  localparam logic [1:0] OP_KEY    = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_ENC    = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_LETTER = 2'd1;
  localparam logic [1:0] ST_NOT_READY  = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [LetterW-1:0] letter_a;
    logic [LetterW-1:0] letter_b;
    logic               has_second;
  } pfe_in_t;

  typedef struct packed {
    logic [LetterW-1:0] cipher_first;
    logic [LetterW-1:0] cipher_second;
    logic [1:0]         status;
  } pfe_out_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic put_key;
    logic put_fill;
    logic set_complete;
    logic load_out;
  } pfe_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic complete;
    logic fill_last;
    logic out_free;
  } pfe_stat_t;

endpackage

@@ sv/pfe_ctrl.sv @@
// Sequencer for the Playfair unit: accepts words and steps the datapath.
// Depends on pfe_pkg.
module pfe_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       in_op,
  output logic             in_stall,
  input  pfe_pkg::pfe_stat_t stat,
  output pfe_pkg::pfe_cmd_t  cmd
);
  import pfe_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_APPEND, S_FILL, S_EMIT} state_t;

  state_t state;
  state_t state_next;

  // Decode next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (in_op)
            OP_KEY:    state_next = S_APPEND;
            OP_FINISH: state_next = stat.complete ? S_EMIT : S_FILL;
            default:   state_next = S_EMIT;
          endcase
        end
      end
      S_APPEND: begin
        cmd.put_key = 1'b1;
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_FILL: begin
        cmd.put_fill = 1'b1;
        if (stat.fill_last) begin
          cmd.set_complete = 1'b1;
          state_next       = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A captured word always moves the controller out of idle in the next cycle
  a_capture_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state != S_IDLE)
    else $error("captured word did not start work");

  // The alphabet walk only runs on an incomplete square
  a_fill_only_incomplete: assert property (@(posedge clk) disable iff (rst)
    cmd.put_fill |-> !stat.complete)
    else $error("fill walk on a complete square");

  // Results are loaded only into a free output slot
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> stat.out_free)
    else $error("output register overwritten");

endmodule

@@ sv/pfe_datapath.sv @@
// Key square, letter-used flags, locate compare and cipher select.
// Depends on pfe_pkg; driven by pfe_ctrl commands.
module pfe_datapath (
  input  logic               clk,
  input  logic               rst,
  input  pfe_pkg::pfe_in_t   in_word,
  input  pfe_pkg::pfe_cmd_t  cmd,
  output pfe_pkg::pfe_stat_t stat,
  output logic               out_valid,
  input  logic               out_stall,
  output pfe_pkg::pfe_out_t  out_word
);
  import pfe_pkg::*;

  // Square storage and fill state
  logic [LetterW-1:0]  key_sq [SqCells];
  logic [LetCount-1:0] letter_used;
  logic [PosW-1:0]     fill_pos;
  logic                complete;
  logic [LetterW-1:0]  fill_cnt;

  // Captured item
  logic [1:0]         item_op;
  logic [LetterW-1:0] item_a;
  logic               bad_a;
  logic               bad_pair;
  logic [SqDim-1:0]   row1, col1, row2, col2;

  // Fold and pad incoming letters
  logic [LetterW-1:0] a_fold, b_fold, b_eff;
  always_comb begin
    a_fold = (in_word.letter_a == LetJ) ? LetI : in_word.letter_a;
    b_fold = (in_word.letter_b == LetJ) ? LetI : in_word.letter_b;
    b_eff  = in_word.has_second ? b_fold : LetX;
    if (b_eff == a_fold) begin
      b_eff = LetX;
    end
  end

  // Locate both letters against every cell at once
  logic [SqCells-1:0] hit_a, hit_b;
  logic [SqDim-1:0]   hrow_a, hcol_a, hrow_b, hcol_b;
  for (genvar k = 0; k < SqCells; k++) begin : g_cmp
    assign hit_a[k] = (key_sq[k] == a_fold);
    assign hit_b[k] = (key_sq[k] == b_eff);
  end
  for (genvar r = 0; r < SqDim; r++) begin : g_rc
    logic [SqDim-1:0] ca, cb;
    for (genvar c = 0; c < SqDim; c++) begin : g_c
      assign ca[c] = hit_a[c * SqDim + r];
      assign cb[c] = hit_b[c * SqDim + r];
    end
    assign hrow_a[r] = |hit_a[r * SqDim +: SqDim];
    assign hrow_b[r] = |hit_b[r * SqDim +: SqDim];
    assign hcol_a[r] = |ca;
    assign hcol_b[r] = |cb;
  end

  // Capture the item and its located rows and columns
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_op  <= in_word.operation;
      item_a   <= a_fold;
      bad_a    <= (in_word.letter_a > LetLast);
      bad_pair <= (in_word.letter_a > LetLast) ||
                  (in_word.has_second && (in_word.letter_b > LetLast));
      row1     <= hrow_a;
      col1     <= hcol_a;
      row2     <= hrow_b;
      col2     <= hcol_b;
    end
  end

  // Choose the letter to place and whether it goes in
  logic [LetterW-1:0] put_val;
  logic               put_en;
  always_comb begin
    put_val = cmd.put_fill ? fill_cnt : item_a;
    put_en  = 1'b0;
    if (cmd.put_fill) begin
      put_en = (fill_cnt != LetJ);
    end else if (cmd.put_key) begin
      put_en = !bad_a && !complete;
    end
    put_en = put_en && (fill_pos < PosW'(SqCells)) && !letter_used[put_val];
  end

  // Write the square cell at the fill position
  always_ff @(posedge clk) begin
    if (put_en) begin
      key_sq[fill_pos] <= put_val;
    end
  end

  // Advance fill state
  always_ff @(posedge clk) begin
    if (rst) begin
      letter_used <= '0;
      fill_pos    <= '0;
      complete    <= 1'b0;
      fill_cnt    <= '0;
    end else begin
      if (put_en) begin
        letter_used[put_val] <= 1'b1;
        fill_pos             <= fill_pos + PosW'(1);
      end
      if (cmd.capture) begin
        fill_cnt <= '0;
      end else if (cmd.put_fill) begin
        fill_cnt <= fill_cnt + LetterW'(1);
      end
      if (cmd.set_complete) begin
        complete <= 1'b1;
      end
    end
  end

  // Apply the row, column or rectangle rule on one-hot coordinates
  logic             same_row, same_col;
  logic [SqDim-1:0] trow1, tcol1, trow2, tcol2;
  always_comb begin
    same_row = (row1 == row2);
    same_col = (col1 == col2);
    trow1 = row1;
    trow2 = row2;
    tcol1 = col2;
    tcol2 = col1;
    if (same_row) begin
      tcol1 = {col1[SqDim-2:0], col1[SqDim-1]};
      tcol2 = {col2[SqDim-2:0], col2[SqDim-1]};
    end else if (same_col) begin
      trow1 = {row1[SqDim-2:0], row1[SqDim-1]};
      trow2 = {row2[SqDim-2:0], row2[SqDim-1]};
      tcol1 = col1;
      tcol2 = col2;
    end
  end

  // Pick the target cells by AND-OR over the square
  logic [LetterW-1:0] pick1 [SqCells];
  logic [LetterW-1:0] pick2 [SqCells];
  logic [LetterW-1:0] cipher1, cipher2;
  for (genvar k = 0; k < SqCells; k++) begin : g_pick
    assign pick1[k] = (trow1[k / SqDim] && tcol1[k % SqDim]) ? key_sq[k] : '0;
    assign pick2[k] = (trow2[k / SqDim] && tcol2[k % SqDim]) ? key_sq[k] : '0;
  end
  always_comb begin
    cipher1 = '0;
    cipher2 = '0;
    for (int k = 0; k < SqCells; k++) begin
      cipher1 = cipher1 | pick1[k];
      cipher2 = cipher2 | pick2[k];
    end
  end

  // Form the result word
  pfe_out_t result;
  always_comb begin
    result = '0;
    case (item_op)
      OP_KEY: begin
        result.status = bad_a ? ST_BAD_LETTER : ST_OK;
      end
      OP_ENC: begin
        if (!complete) begin
          result.status = ST_NOT_READY;
        end else if (bad_pair) begin
          result.status = ST_BAD_LETTER;
        end else begin
          result.cipher_first  = cipher1;
          result.cipher_second = cipher2;
        end
      end
      default: result.status = ST_OK;
    endcase
  end

  // Hold the output word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_word <= result;
    end
  end

  assign stat.complete  = complete;
  assign stat.fill_last = (fill_cnt == LetLast);
  assign stat.out_free  = !out_valid || !out_stall;

  // A complete square has all cells written
  a_complete_full: assert property (@(posedge clk) disable iff (rst)
    complete |-> fill_pos == PosW'(SqCells))
    else $error("square complete with unwritten cells");

  // Completion only clears on reset
  a_complete_sticks: assert property (@(posedge clk) disable iff (rst)
    complete |=> complete)
    else $error("square complete flag dropped");

  // A fresh output word comes only from a load command
  a_out_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("output valid without a load");

endmodule

@@ sv/playfair_digraph_encrypt_unit.sv @@
// Top level of the Playfair digraph encrypt unit: controller plus datapath.
// Depends on pfe_pkg, pfe_ctrl and pfe_datapath.
//
//   channel  direction  handshake            word type
//   in       input      in_valid / in_stall   pfe_in_t
//   out      output     out_valid / out_stall pfe_out_t
//
// Key letter and encrypt words are captured with a parallel compare of both
// letters against all 25 cells, then placed or cipher-selected and loaded.
// A finish word on an incomplete square walks the alphabet one letter a cycle.
// Reset clears the used flags, fill position and completion; the square
// cells themselves are not reset.
// A stalled output holds its word; the next input word may be taken meanwhile,
// and its result waits until the output register is free.
module playfair_digraph_encrypt_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  pfe_pkg::pfe_in_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output pfe_pkg::pfe_out_t out_word
);
  import pfe_pkg::*;

  pfe_cmd_t  cmd;
  pfe_stat_t stat;

  pfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (in_word.operation),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pfe_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

@@ dv/pfe_tb_pkg.sv @@
// Scoreboard for the Playfair digraph encrypt unit testbench: predicts each
// cipher word from the accepted input words and checks the DUT output.
// Depends on pfe_pkg.
package pfe_tb_pkg;
  import pfe_pkg::*;

  // Operation code that the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  class pfe_scoreboard;
    logic [LetterW-1:0] square [SqCells];
    bit                 used [LetCount];
    int unsigned        fill_pos;
    bit                 complete;
    pfe_out_t           cipher_q [$];
    int unsigned        mismatches;

    function new();
      foreach (square[k]) square[k] = '0;
      foreach (used[k]) used[k] = 1'b0;
      fill_pos   = 0;
      complete   = 1'b0;
      mismatches = 0;
    endfunction

    // Append a letter to the square unless it is full or already holds it
    function void place_letter(logic [LetterW-1:0] v);
      if (fill_pos < SqCells && !used[v]) begin
        square[fill_pos] = v;
        used[v]          = 1'b1;
        fill_pos++;
      end
    endfunction

    function int unsigned find_cell(logic [LetterW-1:0] v);
      for (int k = 0; k < SqCells; k++) begin
        if (square[k] == v) return k;
      end
      return 0;
    endfunction

    // Advance the square state for one word and return its cipher word
    function pfe_out_t encipher(pfe_in_t w);
      pfe_out_t           res;
      logic [LetterW-1:0] a;
      logic [LetterW-1:0] b;
      int unsigned        r1, k1, r2, k2;
      res = '0;
      res.status = ST_OK;
      a = w.letter_a;
      b = w.letter_b;
      case (w.operation)
        OP_KEY: begin
          if (a > LetLast) begin
            res.status = ST_BAD_LETTER;
          end else if (!complete) begin
            if (a == LetJ) a = LetI;
            place_letter(a);
          end
        end
        OP_FINISH: begin
          if (!complete) begin
            for (int v = 0; v < LetCount; v++) begin
              if (LetterW'(v) != LetJ) place_letter(LetterW'(v));
            end
            complete = 1'b1;
          end
        end
        OP_ENC: begin
          if (!complete) begin
            res.status = ST_NOT_READY;
          end else if (a > LetLast || (w.has_second && b > LetLast)) begin
            res.status = ST_BAD_LETTER;
          end else begin
            // Pad, fold J to I, then break doubled letters with X
            if (!w.has_second) b = LetX;
            if (a == LetJ) a = LetI;
            if (b == LetJ) b = LetI;
            if (a == b) b = LetX;
            r1 = find_cell(a) / SqDim;
            k1 = find_cell(a) % SqDim;
            r2 = find_cell(b) / SqDim;
            k2 = find_cell(b) % SqDim;
            if (r1 == r2) begin
              res.cipher_first  = square[r1 * SqDim + (k1 + 1) % SqDim];
              res.cipher_second = square[r2 * SqDim + (k2 + 1) % SqDim];
            end else if (k1 == k2) begin
              res.cipher_first  = square[((r1 + 1) % SqDim) * SqDim + k1];
              res.cipher_second = square[((r2 + 1) % SqDim) * SqDim + k2];
            end else begin
              res.cipher_first  = square[r1 * SqDim + k2];
              res.cipher_second = square[r2 * SqDim + k1];
            end
          end
        end
        default: ;
      endcase
      return res;
    endfunction

    function void note_input(pfe_in_t w);
      cipher_q.push_back(encipher(w));
    endfunction

    // Compare an output word against the oldest predicted cipher word
    function void check_result(pfe_out_t got);
      pfe_out_t want;
      if (cipher_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected output word first=%0d second=%0d status=%0d",
                   $realtime, got.cipher_first, got.cipher_second, got.status);
        return;
      end
      want = cipher_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch first exp %0d got %0d, second exp %0d got %0d, %s%0d %s%0d",
                   $realtime, want.cipher_first, got.cipher_first,
                   want.cipher_second, got.cipher_second,
                   "status exp ", want.status, "got ", got.status);
      end
    endfunction

    function int unsigned pending();
      return cipher_q.size();
    endfunction
  endclass

endpackage

@@ dv/tb_top.sv @@
// Top-level testbench for playfair_digraph_encrypt_unit: builds a key square,
// then drives random encrypt traffic with random idling on both channels.
// Depends on pfe_pkg, pfe_tb_pkg and the unit RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pfe_pkg::*;
  import pfe_tb_pkg::*;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_stall;
  pfe_in_t  in_word;
  logic     out_valid;
  logic     out_stall;
  pfe_out_t out_word;

  pfe_scoreboard sb = new();

  playfair_digraph_encrypt_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // Clock, 20 ns period
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Idle length: mostly none or short, sometimes long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic pfe_in_t make_word(logic [1:0] op, logic [LetterW-1:0] a,
                                        logic [LetterW-1:0] b, logic has);
    pfe_in_t w;
    w.operation  = op;
    w.letter_a   = a;
    w.letter_b   = b;
    w.has_second = has;
    return w;
  endfunction

  function automatic logic [LetterW-1:0] rand_letter();
    if ($urandom_range(0, 11) == 0) return LetterW'($urandom_range(26, 31));
    return LetterW'($urandom_range(0, 25));
  endfunction

  // Offer one word, hold it until accepted, then idle for gap cycles
  task automatic send_word(pfe_in_t w, int unsigned gap);
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(w);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stimulus
  initial begin : stim_proc
    int unsigned        key_count;
    int unsigned        pick;
    logic [1:0]         op;
    logic [LetterW-1:0] a;
    logic [LetterW-1:0] b;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_word  = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Encrypt before the square is complete, bad letters included
    send_word(make_word(OP_ENC, 5'd0, 5'd1, 1'b1), idle_len());
    send_word(make_word(OP_ENC, 5'd31, 5'd31, 1'b1), idle_len());
    // Key letters: J folds to I, a repeat is skipped, bad letters flagged
    send_word(make_word(OP_KEY, LetJ, 5'd0, 1'b0), idle_len());
    send_word(make_word(OP_KEY, LetI, 5'd31, 1'b1), idle_len());
    send_word(make_word(OP_KEY, 5'd26, 5'd0, 1'b0), idle_len());
    send_word(make_word(OP_KEY, 5'd31, 5'd0, 1'b0), idle_len());
    send_word(make_word(OP_UNUSED, 5'd31, 5'd31, 1'b1), idle_len());

    // Random key phrase, long enough at times to fill the square
    key_count = $urandom_range(4, 30);
    for (int n = 0; n < key_count; n++) begin
      send_word(make_word(OP_KEY, rand_letter(), LetterW'($urandom_range(0, 31)),
                          1'($urandom_range(0, 1))), idle_len());
    end

    // Finish twice, then key letters that must be ignored
    send_word(make_word(OP_FINISH, 5'd31, 5'd31, 1'b1), idle_len());
    send_word(make_word(OP_FINISH, 5'd0, 5'd0, 1'b0), idle_len());
    send_word(make_word(OP_KEY, 5'd25, 5'd0, 1'b0), idle_len());
    send_word(make_word(OP_KEY, 5'd31, 5'd0, 1'b0), idle_len());

    // Encrypt extremes, padding, doubled letters and bad letters
    send_word(make_word(OP_ENC, 5'd0, 5'd25, 1'b1), idle_len());
    send_word(make_word(OP_ENC, 5'd25, 5'd0, 1'b1), idle_len());
    send_word(make_word(OP_ENC, LetJ, LetJ, 1'b1), idle_len());
    send_word(make_word(OP_ENC, LetI, LetJ, 1'b1), idle_len());
    send_word(make_word(OP_ENC, LetX, 5'd31, 1'b0), idle_len());
    send_word(make_word(OP_ENC, LetX, LetX, 1'b1), idle_len());
    send_word(make_word(OP_ENC, 5'd5, 5'd31, 1'b0), idle_len());
    send_word(make_word(OP_ENC, 5'd26, 5'd1, 1'b1), idle_len());
    send_word(make_word(OP_ENC, 5'd3, 5'd31, 1'b1), idle_len());
    send_word(make_word(OP_ENC, 5'd31, 5'd31, 1'b0), idle_len());

    // Random traffic, mostly encrypt pairs; every hundred words starts
    // with a burst that has no gaps
    for (int n = 0; n < 680; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) op = OP_ENC;
      else if (pick < 88) op = OP_KEY;
      else if (pick < 94) op = OP_FINISH;
      else op = OP_UNUSED;
      a = rand_letter();
      b = rand_letter();
      send_word(make_word(op, a, b, 1'($urandom_range(0, 4) != 0)),
                ((n % 100) < 20) ? 0 : idle_len());
    end
    in_valid <= 1'b0;

    // Drain and let any stray word show up
    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("** playfair_digraph_encrypt_unit: PASSED **");
    end else begin
      $display("** playfair_digraph_encrypt_unit: FAILED **");
    end
    $finish;
  end

  // Output side: random stalls, calm stretches and one long hold-off
  initial begin : drain_proc
    int unsigned taken;
    int unsigned hold_left;
    int unsigned stall_left;
    int unsigned free_left;
    taken      = 0;
    hold_left  = 0;
    stall_left = 0;
    free_left  = 0;
    out_stall  = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        sb.check_result(out_word);
        taken++;
        if (taken == 150) hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (free_left > 0) begin
        free_left--;
        out_stall <= 1'b0;
      end else begin
        stall_left = idle_len();
        free_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 5);
        out_stall <= 1'b0;
      end
    end
  end

  // Stop a hung run
  initial begin : limit_proc
    #5_000_000;
    $display("** playfair_digraph_encrypt_unit: FAILED **");
    $finish;
  end

endmodule
